FILE: src/fcta_pkg.sv
// shared constants, types and codes of the floor/ceiling texel address generator
package fcta_pkg;

    localparam int SCREEN_WIDTH      = 640;
    localparam int SCREEN_HEIGHT     = 480;
    localparam int TEXTURE_SIZE_LOG2 = 6;

    localparam int COLUMN_W = 10;
    localparam int ROW_W    = 8;
    localparam int TEXEL_W  = 12;
    localparam int ADDR_W   = 19;
    localparam int POS_W    = 24;
    localparam int DIR_W    = 16;
    localparam int FLOOR_W  = 40;
    localparam int STEP_W   = 32;

    localparam int S_TDATA_W = ((COLUMN_W + ROW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TEXEL_W + 2 * ADDR_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = POS_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_POS_X = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_Y = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_X = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_Y = CFG_INDEX_W'(3);

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;

    localparam int HALF_HEIGHT = SCREEN_HEIGHT / 2;
    localparam int D_W         = $clog2(HALF_HEIGHT + 1);
    localparam int DIFF_W      = ((ROW_W > D_W) ? ROW_W : D_W) + 1;
    localparam int OPER_W      = DIR_W + 2;
    localparam int NUM_MAG_MAX = 2 * SCREEN_HEIGHT * (1 << DIR_W);
    localparam int NUM_W       = $clog2(NUM_MAG_MAX + 1);
    localparam int QUO_W       = NUM_W + 1;
    localparam int DEN_W       = $clog2(HALF_HEIGHT * SCREEN_WIDTH + 1);
    localparam int CNT_W       = $clog2(NUM_W + 1);

    localparam logic [1:0] OP_FLOOR_X = 2'd0;
    localparam logic [1:0] OP_FLOOR_Y = 2'd1;
    localparam logic [1:0] OP_STEP_X  = 2'd2;
    localparam logic [1:0] OP_STEP_Y  = 2'd3;

    typedef struct packed {
        logic       latch_item;
        logic       div_start;
        logic       div_write;
        logic [1:0] op;
        logic       emit;
        logic       emit_from_input;
    } ctrl_cmd_t;

    typedef struct packed {
        logic col_zero;
        logic div_done;
    } dp_status_t;

endpackage

FILE: src/fcta_divider.sv
// shared restoring divider, one quotient bit per cycle, signed result
module fcta_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [fcta_pkg::NUM_W-1:0]       num_mag,
    input  logic                             num_neg,
    input  logic [fcta_pkg::DEN_W-1:0]       den,
    output logic                             done,
    output logic signed [fcta_pkg::QUO_W-1:0] quotient
);
    import fcta_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, rem_reg, quo_reg[NUM_W-1]} - {2'b00, den_reg};
        if (start) begin
            quo_next  = num_mag;
            rem_next  = '0;
            den_next  = den;
            neg_next  = num_neg;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DEN_W+1]) begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

FILE: src/fcta_datapath.sv
// datapath: view registers, floor point and step state, row setup and output register
module fcta_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fcta_pkg::ctrl_cmd_t                 cmd,
    output fcta_pkg::dp_status_t                status,
    input  logic [fcta_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic [fcta_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    input  logic [fcta_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcta_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcta_pkg::*;

    logic [POS_W-1:0]          pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg;
    logic [FLOOR_W-1:0]        floor_x_reg, floor_x_next;
    logic [FLOOR_W-1:0]        floor_y_reg, floor_y_next;
    logic signed [STEP_W-1:0]  step_x_reg, step_x_next;
    logic signed [STEP_W-1:0]  step_y_reg, step_y_next;
    logic [COLUMN_W-1:0]       column_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [TEXEL_W-1:0]        texel_reg;
    logic [ADDR_W-1:0]         upper_reg, lower_reg;

    logic [COLUMN_W-1:0]       in_column, emit_column;
    logic [ROW_W-1:0]          in_row, emit_row;
    logic signed [DIFF_W-1:0]  diff;
    logic [D_W-1:0]            row_dist;
    logic [DEN_W-1:0]          den;
    logic signed [OPER_W-1:0]  oper;
    logic [NUM_W:0]            scale;
    logic signed [NUM_W:0]     num_s;
    logic [NUM_W:0]            num_abs;
    logic                      div_done;
    logic signed [QUO_W-1:0]   quotient;
    logic [TEXTURE_SIZE_LOG2-1:0] tex_x, tex_y;

    assign in_column = s_tdata[COLUMN_W-1:0];
    assign in_row    = s_tdata[COLUMN_W+ROW_W-1:COLUMN_W];

    assign status.col_zero = (in_column == '0);
    assign status.div_done = div_done;

    // row distance divisor, saturated at one below the horizon
    assign diff = $signed(DIFF_W'(HALF_HEIGHT)) - $signed(DIFF_W'(row_reg));
    assign row_dist = (diff <= 0) ? D_W'(1) : diff[D_W-1:0];

    always_comb begin
        unique case (cmd.op)
            OP_FLOOR_X: begin
                oper  = OPER_W'(dir_x_reg) + OPER_W'(dir_y_reg);
                scale = (NUM_W+1)'(2 * SCREEN_HEIGHT);
                den   = DEN_W'(row_dist);
            end
            OP_FLOOR_Y: begin
                oper  = OPER_W'(dir_y_reg) - OPER_W'(dir_x_reg);
                scale = (NUM_W+1)'(2 * SCREEN_HEIGHT);
                den   = DEN_W'(row_dist);
            end
            OP_STEP_X: begin
                oper  = -OPER_W'(dir_y_reg);
                scale = (NUM_W+1)'(4 * SCREEN_HEIGHT);
                den   = DEN_W'(row_dist) * DEN_W'(SCREEN_WIDTH);
            end
            OP_STEP_Y: begin
                oper  = OPER_W'(dir_x_reg);
                scale = (NUM_W+1)'(4 * SCREEN_HEIGHT);
                den   = DEN_W'(row_dist) * DEN_W'(SCREEN_WIDTH);
            end
            default: begin
                oper  = '0;
                scale = '0;
                den   = '0;
            end
        endcase
        num_s   = $signed((NUM_W+1)'(oper)) * $signed(scale);
        num_abs = num_s[NUM_W] ? (NUM_W+1)'(-num_s) : (NUM_W+1)'(num_s);
    end

    fcta_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num_mag  (num_abs[NUM_W-1:0]),
        .num_neg  (num_s[NUM_W]),
        .den      (den),
        .done     (div_done),
        .quotient (quotient)
    );

    assign emit_column = cmd.emit_from_input ? in_column : column_reg;
    assign emit_row    = cmd.emit_from_input ? in_row : row_reg;
    assign tex_x = floor_x_reg[15 -: TEXTURE_SIZE_LOG2];
    assign tex_y = floor_y_reg[15 -: TEXTURE_SIZE_LOG2];

    always_comb begin
        floor_x_next = floor_x_reg;
        floor_y_next = floor_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        if (cmd.div_write) begin
            unique case (cmd.op)
                OP_FLOOR_X: floor_x_next = FLOOR_W'(pos_x_reg) + FLOOR_W'(quotient);
                OP_FLOOR_Y: floor_y_next = FLOOR_W'(pos_y_reg) + FLOOR_W'(quotient);
                OP_STEP_X:  step_x_next  = STEP_W'(quotient);
                OP_STEP_Y:  step_y_next  = STEP_W'(quotient);
                default:    ;
            endcase
        end else if (cmd.emit) begin
            floor_x_next = floor_x_reg + FLOOR_W'(step_x_reg);
            floor_y_next = floor_y_reg + FLOOR_W'(step_y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= DIR_X_RESET;
            dir_y_reg   <= '0;
            floor_x_reg <= '0;
            floor_y_reg <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_POS_X: pos_x_reg <= cfg_data;
                    CFG_POS_Y: pos_y_reg <= cfg_data;
                    CFG_DIR_X: dir_x_reg <= cfg_data[DIR_W-1:0];
                    CFG_DIR_Y: dir_y_reg <= cfg_data[DIR_W-1:0];
                    default:   ;
                endcase
            end
            floor_x_reg <= floor_x_next;
            floor_y_reg <= floor_y_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
        end
        if (cmd.latch_item) begin
            column_reg <= in_column;
            row_reg    <= in_row;
        end
        if (cmd.emit) begin
            texel_reg <= TEXEL_W'({tex_y, tex_x});
            upper_reg <= ADDR_W'(emit_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(emit_column);
            lower_reg <= (ADDR_W'(SCREEN_HEIGHT - 1) - ADDR_W'(emit_row))
                         * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(emit_column);
        end
    end

    assign m_tdata = M_TDATA_W'({lower_reg, upper_reg, texel_reg});

endmodule

FILE: src/fcta_ctrl.sv
// controller: request handshake, row setup sequence and output valid
module fcta_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  fcta_pkg::dp_status_t  status,
    output fcta_pkg::ctrl_cmd_t   cmd
);
    import fcta_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next          = state_reg;
        op_next             = op_reg;
        cmd.latch_item      = 1'b0;
        cmd.div_start       = 1'b0;
        cmd.div_write       = 1'b0;
        cmd.op              = op_reg;
        cmd.emit            = 1'b0;
        cmd.emit_from_input = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch_item = 1'b1;
                    if (status.col_zero) begin
                        op_next    = OP_FLOOR_X;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.emit            = 1'b1;
                        cmd.emit_from_input = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.div_done) begin
                    cmd.div_write = 1'b1;
                    if (op_reg == OP_STEP_Y) begin
                        state_next = ST_EMIT;
                    end else begin
                        op_next    = op_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_FLOOR_X;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: src/floor_ceiling_texel_address_gen.sv
// top level of the floor/ceiling texel address generator
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata: column, row
//  m_        out        m_tvalid / m_tready    m_tdata: texel index, upper and lower address
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a new request with nonzero column is taken every cycle while the output is not stalled
// a request with column zero runs four divisions on the shared one-bit-per-cycle divider
// the output register holds a result while the next request is taken
// aresetn is synchronous, active low; cfg_ready is always high
module floor_ceiling_texel_address_gen (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // column [9:0], row [17:10]
    input  logic [fcta_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // texel_index [11:0], upper_pixel_address [30:12], lower_pixel_address [49:31]
    output logic [fcta_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcta_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcta_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcta_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fcta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fcta_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
